// File: rtl/bezier_de_casteljau_point_defines.svh
// ----------------------------------------------------------------------------
// Bezier point evaluator: assertion macros
// Shared property templates for the checks at the end of the datapath and sequencer.
// ----------------------------------------------------------------------------
`ifndef BEZIER_DE_CASTELJAU_POINT_DEFINES_SVH
`define BEZIER_DE_CASTELJAU_POINT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// Bezier point evaluator: shared package
// Command codes, microcode word layout and control structs.
// ----------------------------------------------------------------------------
package bdc_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned UPC_W   = 4;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

  // Microprogram addresses
  localparam logic [UPC_W-1:0] U_START = 4'd0;
  localparam logic [UPC_W-1:0] U_LDA   = 4'd1;
  localparam logic [UPC_W-1:0] U_RD    = 4'd2;
  localparam logic [UPC_W-1:0] U_SUB   = 4'd3;
  localparam logic [UPC_W-1:0] U_MUL   = 4'd4;
  localparam logic [UPC_W-1:0] U_SUM   = 4'd5;
  localparam logic [UPC_W-1:0] U_ACC   = 4'd6;
  localparam logic [UPC_W-1:0] U_LVL   = 4'd7;
  localparam logic [UPC_W-1:0] U_OUT   = 4'd8;
  localparam logic [UPC_W-1:0] U_ERR   = 4'd9;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_CTRL0 = 2'd1,
    RD_WORK0 = 2'd2,
    RD_NEXT  = 2'd3
  } rd_sel_t;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_INIT   = 3'd1,
    OP_LOAD_A = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4,
    OP_SUM    = 3'd5,
    OP_ACC    = 3'd6,
    OP_LEVEL  = 3'd7
  } dp_op_t;

  typedef enum logic [2:0] {
    COND_NONE     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_CNT_ZERO = 3'd2,
    COND_LEN_ONE  = 3'd3,
    COND_NOT_LAST = 3'd4,
    COND_OUT_BUSY = 3'd5
  } cond_t;

  typedef struct packed {
    rd_sel_t          rd;
    dp_op_t           op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             fin;
    logic             err;
  } ucw_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    dp_op_t  op;
    logic    emit;
    logic    err;
    logic    busy;
  } seq_ctl_t;

  typedef struct packed {
    logic cnt_zero;
    logic len_one;
    logic not_last;
  } dp_stat_t;

  typedef struct packed {
    logic   st_wr;
    logic   rd_en;
    logic   rd_work;
    dp_op_t op;
  } lane_ctl_t;

endpackage

// File: rtl/bdc_lane.sv
// ----------------------------------------------------------------------------
// Bezier point evaluator: coordinate lane
// Control point store, working store and the shared interpolation unit for
// one coordinate.
// ----------------------------------------------------------------------------
module bdc_lane
  import bdc_pkg::*;
#(
  parameter int unsigned DEPTH       = 32,
  parameter int unsigned T_FRAC_BITS = 16,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned TW = T_FRAC_BITS + 1
) (
  input  logic                      clk,
  input  lane_ctl_t                 lc,
  input  logic [AW-1:0]             st_addr,
  input  logic signed [COORD_W-1:0] st_data,
  input  logic [AW-1:0]             rd_addr,
  input  logic [AW-1:0]             wk_addr,
  input  logic [TW-1:0]             t_val,
  output logic signed [COORD_W-1:0] a_val
);

  localparam int unsigned DW = COORD_W + 1;
  localparam int unsigned NW = TW + DW + 1;
  localparam logic [NW-1:0] BIAS = {{(NW - T_FRAC_BITS){1'b0}}, {T_FRAC_BITS{1'b1}}};

  logic signed [COORD_W-1:0] st_mem [DEPTH];
  logic signed [COORD_W-1:0] wk_mem [DEPTH];

  logic signed [COORD_W-1:0] st_q_r;
  logic signed [COORD_W-1:0] wk_q_r;
  logic                      work_sel_r;
  logic signed [COORD_W-1:0] rd_val;

  logic signed [COORD_W-1:0] a_r;
  logic signed [COORD_W-1:0] b_r;
  logic signed [DW-1:0]      diff_r;
  logic signed [NW-1:0]      prod_r;
  logic signed [NW-1:0]      num_r;
  logic        [NW-1:0]      sum_w;
  logic signed [COORD_W-1:0] res;

  always_ff @(posedge clk) begin
    if (lc.st_wr) begin
      st_mem[st_addr] <= st_data;
    end
  end

  always_ff @(posedge clk) begin
    if (lc.op == OP_ACC) begin
      wk_mem[wk_addr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (lc.rd_en) begin
      st_q_r     <= st_mem[rd_addr];
      wk_q_r     <= wk_mem[rd_addr];
      work_sel_r <= lc.rd_work;
    end
  end

  assign rd_val = work_sel_r ? wk_q_r : st_q_r;

  // Negative numerators get a bias so the shift truncates toward zero.
  assign sum_w = num_r + (num_r[NW-1] ? BIAS : '0);
  assign res   = sum_w[T_FRAC_BITS +: COORD_W];

  // a + t*(b - a), scaled by 2^T, then divided back down.
  always_ff @(posedge clk) begin
    unique case (lc.op)
      OP_LOAD_A: a_r <= rd_val;
      OP_SUB: begin
        b_r    <= rd_val;
        diff_r <= DW'(rd_val) - DW'(a_r);
      end
      OP_MUL:  prod_r <= $signed({1'b0, t_val}) * diff_r;
      OP_SUM:  num_r  <= (NW'(a_r) <<< T_FRAC_BITS) + prod_r;
      OP_ACC:  a_r    <= b_r;
      default: ;
    endcase
  end

  assign a_val = a_r;

endmodule

// File: rtl/bdc_dp.sv
// ----------------------------------------------------------------------------
// Bezier point evaluator: datapath
// Point count, level and index counters, parameter register and the x and y
// lanes.
// ----------------------------------------------------------------------------
`include "bezier_de_casteljau_point_defines.svh"

module bdc_dp
  import bdc_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 32,
  parameter int unsigned T_FRAC_BITS = 16,
  localparam int unsigned TW = T_FRAC_BITS + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      host_acc,
  input  logic [CMD_W-1:0]          host_cmd,
  input  logic signed [COORD_W-1:0] host_x,
  input  logic signed [COORD_W-1:0] host_y,
  input  logic [TW-1:0]             host_t,
  input  seq_ctl_t                  ctl,
  output dp_stat_t                  stat,
  output logic signed [COORD_W-1:0] res_x,
  output logic signed [COORD_W-1:0] res_y
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic          first_r, first_nxt;
  logic [TW-1:0] t_r;
  logic          append_ok;
  logic [AW-1:0] rd_addr;
  lane_ctl_t     lc;

  assign append_ok = host_acc && (host_cmd == CMD_APPEND) && (count_r < CW'(MAX_POINTS));

  always_comb begin
    count_nxt = count_r;
    len_nxt   = len_r;
    i_nxt     = i_r;
    first_nxt = first_r;
    if (host_acc && (host_cmd == CMD_CLEAR)) begin
      count_nxt = '0;
    end else if (append_ok) begin
      count_nxt = count_r + 1'b1;
    end
    unique case (ctl.op)
      OP_INIT: begin
        len_nxt   = count_r;
        i_nxt     = '0;
        first_nxt = 1'b1;
      end
      OP_ACC: i_nxt = i_r + 1'b1;
      OP_LEVEL: begin
        len_nxt   = len_r - 1'b1;
        i_nxt     = '0;
        first_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      len_r   <= '0;
      i_r     <= '0;
      first_r <= 1'b1;
    end else begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
      i_r     <= i_nxt;
      first_r <= first_nxt;
    end
  end

  // Parameters above 1.0 saturate.
  always_ff @(posedge clk) begin
    if (host_acc && (host_cmd == CMD_EVAL)) begin
      t_r <= (host_t > T_ONE) ? T_ONE : host_t;
    end
  end

  assign rd_addr = (ctl.rd_sel == RD_NEXT) ? i_r + 1'b1 : '0;

  // The first level reads the control points, later levels the working store.
  always_comb begin
    lc.st_wr   = append_ok;
    lc.rd_en   = (ctl.rd_sel != RD_NONE);
    lc.rd_work = (ctl.rd_sel == RD_WORK0) || ((ctl.rd_sel == RD_NEXT) && !first_r);
    lc.op      = ctl.op;
  end

  assign stat.cnt_zero = (count_r == '0);
  assign stat.len_one  = (len_r == CW'(1));
  assign stat.not_last = ((CW'(i_r) + CW'(2)) != len_r);

  bdc_lane #(
    .DEPTH       (MAX_POINTS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lane_x (
    .clk     (clk),
    .lc      (lc),
    .st_addr (count_r[AW-1:0]),
    .st_data (host_x),
    .rd_addr (rd_addr),
    .wk_addr (i_r),
    .t_val   (t_r),
    .a_val   (res_x)
  );

  bdc_lane #(
    .DEPTH       (MAX_POINTS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lane_y (
    .clk     (clk),
    .lc      (lc),
    .st_addr (count_r[AW-1:0]),
    .st_data (host_y),
    .rd_addr (rd_addr),
    .wk_addr (i_r),
    .t_val   (t_r),
    .a_val   (res_y)
  );

  `BDC_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CW'(MAX_POINTS), "point count over capacity")

endmodule

// File: rtl/bdc_useq.sv
// ----------------------------------------------------------------------------
// Bezier point evaluator: microcode sequencer
// Control store, micro program counter and branch conditions for one
// evaluation.
// ----------------------------------------------------------------------------
`include "bezier_de_casteljau_point_defines.svh"

module bdc_useq
  import bdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     out_busy,
  input  dp_stat_t stat,
  output seq_ctl_t ctl
);

  function automatic ucw_t ucode(input logic [UPC_W-1:0] addr);
    ucw_t w;
    w.rd     = RD_NONE;
    w.op     = OP_NOP;
    w.cond   = COND_NONE;
    w.target = U_START;
    w.fin    = 1'b0;
    w.err    = 1'b0;
    unique case (addr)
      U_START: begin
        w.rd     = RD_CTRL0;
        w.op     = OP_INIT;
        w.cond   = COND_CNT_ZERO;
        w.target = U_ERR;
      end
      U_LDA: begin
        w.op     = OP_LOAD_A;
        w.cond   = COND_LEN_ONE;
        w.target = U_OUT;
      end
      U_RD:  w.rd = RD_NEXT;
      U_SUB: w.op = OP_SUB;
      U_MUL: w.op = OP_MUL;
      U_SUM: w.op = OP_SUM;
      U_ACC: begin
        w.op     = OP_ACC;
        w.cond   = COND_NOT_LAST;
        w.target = U_RD;
      end
      U_LVL: begin
        w.rd     = RD_WORK0;
        w.op     = OP_LEVEL;
        w.cond   = COND_ALWAYS;
        w.target = U_LDA;
      end
      U_OUT: begin
        w.cond   = COND_OUT_BUSY;
        w.target = U_OUT;
        w.fin    = 1'b1;
      end
      U_ERR: begin
        w.cond   = COND_OUT_BUSY;
        w.target = U_ERR;
        w.fin    = 1'b1;
        w.err    = 1'b1;
      end
      default: ;
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             busy_r, busy_nxt;
  ucw_t             w;
  logic             taken;
  logic             emit;

  assign w = ucode(upc_r);

  always_comb begin
    unique case (w.cond)
      COND_NONE:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_CNT_ZERO: taken = stat.cnt_zero;
      COND_LEN_ONE:  taken = stat.len_one;
      COND_NOT_LAST: taken = stat.not_last;
      COND_OUT_BUSY: taken = out_busy;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    emit     = 1'b0;
    if (!busy_r) begin
      busy_nxt = start;
    end else if (taken) begin
      upc_nxt = w.target;
    end else if (w.fin) begin
      busy_nxt = 1'b0;
      upc_nxt  = U_START;
      emit     = 1'b1;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= U_START;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

  // While idle the datapath must see no operation, or INIT would run.
  always_comb begin
    ctl.rd_sel = busy_r ? w.rd : RD_NONE;
    ctl.op     = busy_r ? w.op : OP_NOP;
    ctl.emit   = emit;
    ctl.err    = w.err;
    ctl.busy   = busy_r;
  end

  `BDC_ASSERT_NXT(a_start_enters, clk, rst_n, start && !busy_r, busy_r && (upc_r == U_START), "evaluation did not begin at the program start")
  `BDC_ASSERT_IMP(a_idle_parked, clk, rst_n, !busy_r, upc_r == U_START, "sequencer idle away from the program start")
  `BDC_ASSERT_NXT(a_emit_once, clk, rst_n, ctl.emit, !busy_r && !ctl.emit, "result emitted without returning to idle")

endmodule

// File: rtl/bezier_de_casteljau_point.sv
// ----------------------------------------------------------------------------
// Bezier point evaluator: top level
// Stores signed control points and evaluates the curve at a Q fraction t by
// de Casteljau reduction, truncating each interpolation toward zero.
//
//   channel  dir   handshake           payload
//   in_      in    tvalid / tready     tuser: cmd; tdata: point_x, point_y, t_frac
//   out_     out   tvalid / tready     tuser: status; tdata: curve_x, curve_y
//
// An evaluation holds in_tready low while one shared interpolation unit per lane
// takes five microcode steps a pair. The result is valid in the cycle after the
// final step, as in_tready returns high.
// Reset clears the point count, the level counters, the sequencer and out_tvalid.
// A result still waiting in the output register holds the program at its last step.
// ----------------------------------------------------------------------------
module bezier_de_casteljau_point
  import bdc_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 32,
  parameter int unsigned T_FRAC_BITS = 16,
  localparam int unsigned TW    = T_FRAC_BITS + 1,
  localparam int unsigned IN_DW = ((2 * COORD_W + TW + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DW-1:0]       in_tdata,   // point_x, point_y, t_frac, zero pad
  input  logic [CMD_W-1:0]       in_tuser,   // cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [2*COORD_W-1:0]   out_tdata,  // curve_x, curve_y
  output logic                   out_tuser   // status
);

  seq_ctl_t                  ctl;
  dp_stat_t                  stat;
  logic                      in_acc;
  logic                      out_busy;
  logic signed [COORD_W-1:0] res_x;
  logic signed [COORD_W-1:0] res_y;

  logic                      out_valid_r, out_valid_nxt;
  logic [2*COORD_W-1:0]      out_data_r;
  logic                      out_user_r;

  assign in_tready = !ctl.busy;
  assign in_acc    = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;

  bdc_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && (in_tuser == CMD_EVAL)),
    .out_busy (out_busy),
    .stat     (stat),
    .ctl      (ctl)
  );

  bdc_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .host_acc (in_acc),
    .host_cmd (in_tuser),
    .host_x   (in_tdata[COORD_W-1:0]),
    .host_y   (in_tdata[2*COORD_W-1:COORD_W]),
    .host_t   (in_tdata[2*COORD_W +: TW]),
    .ctl      (ctl),
    .stat     (stat),
    .res_x    (res_x),
    .res_y    (res_y)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // An empty point list answers with a zero point and the error flag.
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_data_r <= ctl.err ? '0 : {res_y, res_x};
      out_user_r <= ctl.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
